// ----- design/pfsp_pkg.sv -----
// Package with the phase type, character codes and helpers of the printf specifier parser.
package pfsp_pkg;

   typedef enum logic [2:0] {
      PH_FLAGS   = 3'd0,
      PH_WDIGITS = 3'd1,
      PH_AFTER_W = 3'd2,
      PH_DOT     = 3'd3,
      PH_PDIGITS = 3'd4,
      PH_AFTER_P = 3'd5
   } phase_type;

   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_PERCENT = 8'h25;

   localparam logic [30:0] INT_SAT = 31'h7FFF_FFFF;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 80;

   typedef struct packed {
      logic        spec_error;
      logic [7:0]  end_char;
      logic [31:0] precision_value;
      logic        precision_given;
      logic [30:0] width_value;
      logic        width_given;
      logic        zero_pad;
      logic        left_justify;
   } result_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_conv(input logic [7:0] c);
      return (c == 8'h63) || (c == 8'h73) || (c == 8'h64) || (c == 8'h69) ||
             (c == 8'h70) || (c == 8'h75) || (c == 8'h78) || (c == 8'h58) ||
             (c == CH_PERCENT);
   endfunction

   // Decimal accumulate acc * 10 + digit, saturating at the largest int.
   function automatic logic [30:0] sat_accum(input logic [30:0] acc, input logic [7:0] c);
      logic [34:0] prod;
      logic [34:0] sum;
      prod = ({4'd0, acc} << 3) + ({4'd0, acc} << 1);
      sum  = prod + {31'd0, c[3:0]};
      if (sum > {4'd0, INT_SAT}) begin
         return INT_SAT;
      end
      return sum[30:0];
   endfunction

endpackage

// ----- design/printf_format_spec_parser.sv -----
// Top level of the printf conversion specifier parser, one character per transaction.
// A result passes from the input register, through the phase decode, into the result register.
// One character is taken per cycle, unless a full, undrained result register holds up an ending character.
// The input register and the result register each hold one transaction.
// Reset is synchronous and active high; it returns the parser to the flags phase.
// Reset empties both registers and clears the phase and accumulator fields; stored data is not reset.
module printf_format_spec_parser (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // format_char [7:0], star_value [39:8]
   input  logic [pfsp_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // left_justify, zero_pad, width_given, width_value [33:3], precision_given,
   // precision_value [66:35], end_char [74:67], spec_error, zero fill [79:76]
   output logic [pfsp_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   logic                 in_valid_ff;
   logic [7:0]           in_char_ff;
   logic [31:0]          in_star_ff;

   pfsp_pkg::phase_type  phase_ff, phase_in;
   logic                 left_ff, left_in;
   logic                 zero_ff, zero_in;
   logic                 wseen_ff, wseen_in;
   logic [30:0]          waccum_ff, waccum_in;
   logic                 pseen_ff, pseen_in;
   logic [31:0]          paccum_ff, paccum_in;

   logic                 rsp_valid_ff;
   pfsp_pkg::result_type rsp_data_ff;
   pfsp_pkg::result_type result;

   logic                 emit;
   logic                 advance;
   logic                 c_digit;
   logic                 star_neg;
   logic [30:0]          star_mag;

   assign c_digit  = pfsp_pkg::is_digit(in_char_ff);
   assign star_neg = in_star_ff[31];
   assign star_mag = (in_star_ff == 32'h8000_0000) ? pfsp_pkg::INT_SAT
                                                    : 31'((~in_star_ff) + 32'd1);

   always_comb begin
      phase_in = phase_ff;
      emit     = 1'b0;
      unique case (phase_ff)
         pfsp_pkg::PH_WDIGITS: begin
            if (c_digit) begin
               phase_in = pfsp_pkg::PH_WDIGITS;
            end else if (in_char_ff == pfsp_pkg::CH_DOT) begin
               phase_in = pfsp_pkg::PH_DOT;
            end else begin
               emit = 1'b1;
            end
         end
         pfsp_pkg::PH_AFTER_W: begin
            if (in_char_ff == pfsp_pkg::CH_DOT) begin
               phase_in = pfsp_pkg::PH_DOT;
            end else begin
               emit = 1'b1;
            end
         end
         pfsp_pkg::PH_DOT: begin
            if (in_char_ff == pfsp_pkg::CH_STAR) begin
               phase_in = pfsp_pkg::PH_AFTER_P;
            end else if (c_digit) begin
               phase_in = pfsp_pkg::PH_PDIGITS;
            end else begin
               emit = 1'b1;
            end
         end
         pfsp_pkg::PH_PDIGITS: begin
            if (!c_digit) begin
               emit = 1'b1;
            end
         end
         pfsp_pkg::PH_AFTER_P: begin
            emit = 1'b1;
         end
         default: begin
            if (in_char_ff == pfsp_pkg::CH_MINUS || in_char_ff == pfsp_pkg::CH_ZERO) begin
               phase_in = pfsp_pkg::PH_FLAGS;
            end else if (in_char_ff == pfsp_pkg::CH_STAR) begin
               phase_in = pfsp_pkg::PH_AFTER_W;
            end else if (c_digit) begin
               phase_in = pfsp_pkg::PH_WDIGITS;
            end else if (in_char_ff == pfsp_pkg::CH_DOT) begin
               phase_in = pfsp_pkg::PH_DOT;
            end else begin
               emit = 1'b1;
            end
         end
      endcase
      if (emit) begin
         phase_in = pfsp_pkg::PH_FLAGS;
      end
   end

   always_comb begin
      left_in   = left_ff;
      zero_in   = zero_ff;
      wseen_in  = wseen_ff;
      waccum_in = waccum_ff;
      pseen_in  = pseen_ff;
      paccum_in = paccum_ff;
      unique case (phase_ff)
         pfsp_pkg::PH_WDIGITS: begin
            if (c_digit) begin
               waccum_in = pfsp_pkg::sat_accum(waccum_ff, in_char_ff);
            end else if (in_char_ff == pfsp_pkg::CH_DOT) begin
               pseen_in = 1'b1;
            end
         end
         pfsp_pkg::PH_AFTER_W: begin
            if (in_char_ff == pfsp_pkg::CH_DOT) begin
               pseen_in = 1'b1;
            end
         end
         pfsp_pkg::PH_DOT: begin
            if (in_char_ff == pfsp_pkg::CH_STAR) begin
               paccum_in = in_star_ff;
               if (star_neg) begin
                  pseen_in = 1'b0;
               end
            end else if (c_digit) begin
               paccum_in = {1'b0, pfsp_pkg::sat_accum(31'd0, in_char_ff)};
            end else begin
               paccum_in = 32'd0;
            end
         end
         pfsp_pkg::PH_PDIGITS: begin
            if (c_digit) begin
               paccum_in = {1'b0, pfsp_pkg::sat_accum(paccum_ff[30:0], in_char_ff)};
            end
         end
         pfsp_pkg::PH_AFTER_P: begin
            paccum_in = paccum_ff;
         end
         default: begin
            if (in_char_ff == pfsp_pkg::CH_MINUS) begin
               left_in = 1'b1;
            end else if (in_char_ff == pfsp_pkg::CH_ZERO) begin
               if (!left_ff) begin
                  zero_in = 1'b1;
               end
            end else if (in_char_ff == pfsp_pkg::CH_STAR) begin
               wseen_in = 1'b1;
               if (star_neg) begin
                  waccum_in = star_mag;
                  left_in   = 1'b1;
                  zero_in   = 1'b0;
               end else begin
                  waccum_in = in_star_ff[30:0];
               end
            end else if (c_digit) begin
               wseen_in  = 1'b1;
               waccum_in = pfsp_pkg::sat_accum(31'd0, in_char_ff);
            end else if (in_char_ff == pfsp_pkg::CH_DOT) begin
               pseen_in = 1'b1;
            end
         end
      endcase

      result.left_justify    = left_in;
      result.zero_pad        = zero_in;
      result.width_given     = wseen_in;
      result.width_value     = waccum_in;
      result.precision_given = pseen_in;
      result.precision_value = paccum_in;
      result.end_char        = in_char_ff;
      result.spec_error      = !pfsp_pkg::is_conv(in_char_ff);

      if (emit) begin
         left_in   = 1'b0;
         zero_in   = 1'b0;
         wseen_in  = 1'b0;
         waccum_in = 31'd0;
         pseen_in  = 1'b0;
         paccum_in = 32'd0;
      end
   end

   assign advance    = in_valid_ff && (!emit || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_char_ff <= req_tdata[7:0];
         in_star_ff <= req_tdata[39:8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= pfsp_pkg::PH_FLAGS;
         left_ff   <= 1'b0;
         zero_ff   <= 1'b0;
         wseen_ff  <= 1'b0;
         waccum_ff <= 31'd0;
         pseen_ff  <= 1'b0;
         paccum_ff <= 32'd0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         left_ff   <= left_in;
         zero_ff   <= zero_in;
         wseen_ff  <= wseen_in;
         waccum_ff <= waccum_in;
         pseen_ff  <= pseen_in;
         paccum_ff <= paccum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance && emit) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_data_ff};

   a_emit_restarts: assert property (@(posedge clock) disable iff (reset)
      (advance && emit) |=> (phase_ff == pfsp_pkg::PH_FLAGS && !wseen_ff && !pseen_ff))
      else $error("parser did not restart after a result");

   a_width_clear: assert property (@(posedge clock) disable iff (reset)
      !wseen_ff |-> (waccum_ff == 31'd0))
      else $error("width value without a width");

   a_precision_phase: assert property (@(posedge clock) disable iff (reset)
      pseen_ff |-> (phase_ff == pfsp_pkg::PH_DOT || phase_ff == pfsp_pkg::PH_PDIGITS ||
                    phase_ff == pfsp_pkg::PH_AFTER_P))
      else $error("precision flag outside the precision phases");

   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_char_ff) && $stable(in_star_ff)))
      else $error("stalled character was lost");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the printf conversion specifier parser stream block.
`timescale 1ns / 100ps

module tb_top;

   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int unsigned CHAR_TARGET = 1500;
   localparam int unsigned PACING_SPAN = 300;
   localparam int unsigned TAIL_CYCLES = 8;
   localparam string CONV_CHARS = "csdipuxX%";

   typedef struct {
      logic [7:0]  ch;
      logic [31:0] star;
      int unsigned gap_pct;
      int unsigned stall_pct;
      bit          drain_first;
   } spec_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [pfsp_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [pfsp_pkg::RSP_DATA_W-1:0] rsp_tdata;

   spec_byte_type pending_chars[$];
   spec_byte_type in_flight;
   pfsp_pkg::result_type expected_specs[$];
   pfsp_pkg::result_type want;
   pfsp_pkg::result_type got;

   int unsigned recv_stall_pct = 0;
   int unsigned cur_gap_pct = 0;
   int unsigned cur_stall_pct = 0;
   bit drain_next = 1'b0;

   int unsigned quiet_cycles = 0;
   int unsigned failures = 0;
   int unsigned chars_accepted = 0;
   int unsigned specs_checked = 0;
   int unsigned malformed_specs = 0;

   // Predictor state for the specification in progress.
   pfsp_pkg::phase_type spec_phase = pfsp_pkg::PH_FLAGS;
   logic        left_seen = 1'b0;
   logic        zero_seen = 1'b0;
   logic        width_seen = 1'b0;
   logic [31:0] width_val = '0;
   logic        prec_seen = 1'b0;
   logic [31:0] prec_val = '0;

   printf_format_spec_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic is_decimal(input logic [7:0] ch);
      return ch >= pfsp_pkg::CH_ZERO && ch <= pfsp_pkg::CH_NINE;
   endfunction

   function automatic logic is_conversion_char(input logic [7:0] ch);
      return ch == "c" || ch == "s" || ch == "d" || ch == "i" || ch == "p" ||
             ch == "u" || ch == "x" || ch == "X" || ch == pfsp_pkg::CH_PERCENT;
   endfunction

   function automatic logic [31:0] decimal_push(input logic [31:0] acc, input logic [7:0] ch);
      logic [35:0] total;
      total = {4'd0, acc} * 36'd10 + {32'd0, ch[3:0]};
      if (total > 36'h0_7FFF_FFFF) begin
         return 32'h7FFF_FFFF;
      end
      return total[31:0];
   endfunction

   task automatic close_spec(input logic [7:0] ch);
      pfsp_pkg::result_type r;
      r.left_justify    = left_seen;
      r.zero_pad        = zero_seen;
      r.width_given     = width_seen;
      r.width_value     = width_val[30:0];
      r.precision_given = prec_seen;
      r.precision_value = prec_val;
      r.end_char        = ch;
      r.spec_error      = !is_conversion_char(ch);
      expected_specs.push_back(r);
      spec_phase = pfsp_pkg::PH_FLAGS;
      left_seen  = 1'b0;
      zero_seen  = 1'b0;
      width_seen = 1'b0;
      width_val  = '0;
      prec_seen  = 1'b0;
      prec_val   = '0;
   endtask

   task automatic parse_spec_char(input logic [7:0] ch, input logic [31:0] star);
      logic [31:0] mag;
      case (spec_phase)
         pfsp_pkg::PH_WDIGITS: begin
            if (is_decimal(ch)) begin
               width_val = decimal_push(width_val, ch);
            end else if (ch == pfsp_pkg::CH_DOT) begin
               prec_seen = 1'b1;
               spec_phase = pfsp_pkg::PH_DOT;
            end else begin
               close_spec(ch);
            end
         end
         pfsp_pkg::PH_AFTER_W: begin
            if (ch == pfsp_pkg::CH_DOT) begin
               prec_seen = 1'b1;
               spec_phase = pfsp_pkg::PH_DOT;
            end else begin
               close_spec(ch);
            end
         end
         pfsp_pkg::PH_DOT: begin
            if (ch == pfsp_pkg::CH_STAR) begin
               prec_val = star;
               if (star[31]) begin
                  prec_seen = 1'b0;
               end
               spec_phase = pfsp_pkg::PH_AFTER_P;
            end else if (is_decimal(ch)) begin
               prec_val = decimal_push(32'd0, ch);
               spec_phase = pfsp_pkg::PH_PDIGITS;
            end else begin
               prec_val = '0;
               close_spec(ch);
            end
         end
         pfsp_pkg::PH_PDIGITS: begin
            if (is_decimal(ch)) begin
               prec_val = decimal_push(prec_val, ch);
            end else begin
               close_spec(ch);
            end
         end
         pfsp_pkg::PH_AFTER_P: begin
            close_spec(ch);
         end
         default: begin
            if (ch == pfsp_pkg::CH_MINUS) begin
               left_seen = 1'b1;
            end else if (ch == pfsp_pkg::CH_ZERO) begin
               if (!left_seen) begin
                  zero_seen = 1'b1;
               end
            end else if (ch == pfsp_pkg::CH_STAR) begin
               width_seen = 1'b1;
               if (star[31]) begin
                  mag = -star;
                  width_val = (mag > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag;
                  left_seen = 1'b1;
                  zero_seen = 1'b0;
               end else begin
                  width_val = star;
               end
               spec_phase = pfsp_pkg::PH_AFTER_W;
            end else if (is_decimal(ch)) begin
               width_seen = 1'b1;
               width_val = decimal_push(32'd0, ch);
               spec_phase = pfsp_pkg::PH_WDIGITS;
            end else if (ch == pfsp_pkg::CH_DOT) begin
               prec_seen = 1'b1;
               spec_phase = pfsp_pkg::PH_DOT;
            end else begin
               close_spec(ch);
            end
         end
      endcase
   endtask

   function automatic logic [31:0] random_star();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return $urandom_range(40);
         4: return -$urandom_range(40);
         default: return $urandom;
      endcase
   endfunction

   task automatic add_char(input logic [7:0] ch, input logic [31:0] star);
      spec_byte_type b;
      b.ch = ch;
      b.star = star;
      b.gap_pct = cur_gap_pct;
      b.stall_pct = cur_stall_pct;
      b.drain_first = drain_next;
      drain_next = 1'b0;
      pending_chars.push_back(b);
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         add_char(s[i], random_star());
      end
   endtask

   task automatic add_digits(input bit lead_nonzero);
      int unsigned count;
      count = ($urandom_range(19) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 3);
      for (int unsigned i = 0; i < count; i++) begin
         if (i == 0 && lead_nonzero) begin
            add_char(pfsp_pkg::CH_ZERO + 8'($urandom_range(1, 9)), random_star());
         end else begin
            add_char(pfsp_pkg::CH_ZERO + 8'($urandom_range(9)), random_star());
         end
      end
   endtask

   task automatic add_random_spec();
      int unsigned flag_count;
      if ($urandom_range(99) < 12) begin
         add_char(8'($urandom_range(255)), random_star());
         return;
      end
      flag_count = $urandom_range(3);
      for (int unsigned i = 0; i < flag_count; i++) begin
         add_char($urandom_range(1) ? pfsp_pkg::CH_MINUS : pfsp_pkg::CH_ZERO, random_star());
      end
      case ($urandom_range(3))
         0: ;
         1: add_char(pfsp_pkg::CH_STAR, random_star());
         default: add_digits(1'b1);
      endcase
      if ($urandom_range(1)) begin
         add_char(pfsp_pkg::CH_DOT, random_star());
         case ($urandom_range(2))
            0: ;
            1: add_char(pfsp_pkg::CH_STAR, random_star());
            default: add_digits(1'b0);
         endcase
      end
      if ($urandom_range(99) < 80) begin
         add_char(CONV_CHARS[$urandom_range(CONV_CHARS.len() - 1)], random_star());
      end else begin
         add_char(8'($urandom_range(255)), random_star());
      end
   endtask

   task automatic set_pacing(input int unsigned phase_index);
      case (phase_index % 5)
         1: begin cur_gap_pct = 48; cur_stall_pct = 0; end
         2: begin cur_gap_pct = 0; cur_stall_pct = 48; end
         3: begin cur_gap_pct = 18; cur_stall_pct = 18; end
         default: begin cur_gap_pct = 0; cur_stall_pct = 0; end
      endcase
      drain_next = 1'b1;
   endtask

   // Driver: presents queued characters and feeds every accepted one to the predictor.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            parse_spec_char(in_flight.ch, in_flight.star);
            chars_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_chars.size() != 0 &&
                $urandom_range(99) >= pending_chars[0].gap_pct &&
                (!pending_chars[0].drain_first || expected_specs.size() == 0)) begin
               in_flight = pending_chars.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {in_flight.star, in_flight.ch};
               recv_stall_pct <= in_flight.stall_pct;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= $urandom_range(99) >= recv_stall_pct;
      end
   end

   // Monitor: every result transaction is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[75:0];
         if (expected_specs.size() == 0) begin
            failures++;
            if (failures <= 10) begin
               $display("Unexpected result: end_char=%h data=%h", got.end_char, rsp_tdata);
            end
         end else begin
            want = expected_specs.pop_front();
            specs_checked++;
            if (want.spec_error) begin
               malformed_specs++;
            end
            if ({4'd0, want} !== rsp_tdata) begin
               failures++;
               if (failures <= 10) begin
                  $display("Mismatch on spec %0d:", specs_checked);
                  $display("  expected lj=%b zp=%b wg=%b w=%0d pg=%b p=%0d end=%h err=%b",
                           want.left_justify, want.zero_pad, want.width_given,
                           want.width_value, want.precision_given,
                           $signed(want.precision_value), want.end_char, want.spec_error);
                  $display("  actual   lj=%b zp=%b wg=%b w=%0d pg=%b p=%0d end=%h err=%b fill=%h",
                           got.left_justify, got.zero_pad, got.width_given,
                           got.width_value, got.precision_given,
                           $signed(got.precision_value), got.end_char, got.spec_error,
                           rsp_tdata[79:76]);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired with %0d results outstanding.", expected_specs.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      int unsigned next_switch;
      int unsigned phase_index;

      // Directed specifications, no idling on either side.
      add_text("d");
      add_text("0-50i");
      add_char(pfsp_pkg::CH_STAR, 32'h8000_0000);
      add_char(pfsp_pkg::CH_DOT, random_star());
      add_char(pfsp_pkg::CH_STAR, 32'hFFFF_FFFF);
      add_text("X");
      add_char(pfsp_pkg::CH_STAR, 32'h7FFF_FFFF);
      add_text(".q");
      add_text(".9999999999u");
      add_text("%");
      add_char(8'h00, 32'h0000_0000);
      add_char(8'hFF, 32'hFFFF_FFFF);
      add_text("7*");
      add_char(pfsp_pkg::CH_DOT, random_star());
      add_char(pfsp_pkg::CH_STAR, 32'd12);
      add_text("5");
      add_text("1.p");

      phase_index = 1;
      next_switch = pending_chars.size() + PACING_SPAN;
      set_pacing(phase_index);
      while (pending_chars.size() < CHAR_TARGET) begin
         if (pending_chars.size() >= next_switch) begin
            phase_index++;
            next_switch += PACING_SPAN;
            set_pacing(phase_index);
         end
         add_random_spec();
      end
      add_text("d");

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      while (pending_chars.size() != 0 || req_tvalid || expected_specs.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d characters; checked %0d specifications, %0d of them malformed,",
               chars_accepted, specs_checked, malformed_specs);
      $display("under steady, sender-gapped, receiver-stalled and mixed pacing.");
      if (failures == 0 && expected_specs.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
